@@ design/kinematic_bicycle_step_core_assert.svh @@
// assertion macros shared by the step core
`ifndef KINEMATIC_BICYCLE_STEP_CORE_ASSERT_SVH
`define KINEMATIC_BICYCLE_STEP_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define KBS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kbs check failed");

// next-cycle implication, checked out of reset
`define KBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kbs check failed");

`endif

@@ design/kbs_pkg.sv @@
// shared types, constants and the cordic angle table for the step core
`timescale 1ns / 1ps

package kbs_pkg;

  // register indexes of the configuration port
  localparam logic [1:0] CFG_WB    = 2'd0;
  localparam logic [1:0] CFG_ACCEL = 2'd1;
  localparam logic [1:0] CFG_STEER = 2'd2;

  // register reset values and limits
  localparam logic [12:0] WB_RESET    = 13'd640;
  localparam logic [12:0] ACCEL_RESET = 13'd256;
  localparam logic [12:0] WB_MIN      = 13'd128;
  localparam logic [12:0] WB_MAX      = 13'd4096;
  localparam logic signed [12:0] ACCEL_LIM = 13'sd2048;
  localparam logic signed [14:0] STEER_LIM = 15'sd14563;
  localparam logic signed [23:0] SPEED_LIM = 24'sd6553600;

  // state reset values
  localparam logic [31:0] X_RESET = 32'd276409;
  localparam logic [31:0] Y_RESET = 32'd1640024;

  // cordic gain in Q30 and 2^32 / (2 pi)
  localparam longint unsigned GAIN_Q30 = 64'd652032874;
  localparam logic [29:0] INV_2PI_Q32 = 30'd683565276;

  // divider widths
  localparam int DIV_W = 46;
  localparam int DEN_W = 28;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic dist_calc;
    logic cordic_go;
    logic trig_steer;
    logic pos_mul;
    logic pos_add;
    logic div_go;
    logic div_turn;
    logic tan_mul;
    logic mul_lo;
    logic mul_hi;
    logic finish;
  } kbs_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic cordic_busy;
    logic div_busy;
    logic out_full;
  } kbs_sts_t;

  // atan(2^-i), 2^32 per turn
  function automatic logic [31:0] atan_ang(input logic [4:0] idx);
    logic [31:0] a;
    unique case (idx)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051D;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2E;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2F9;
      5'd15: a = 32'h0000517C;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A2F;
      5'd19: a = 32'h00000517;
      5'd20: a = 32'h0000028B;
      5'd21: a = 32'h00000145;
      5'd22: a = 32'h000000A2;
      5'd23: a = 32'h00000051;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

endpackage

@@ design/kbs_cordic.sv @@
// iterative rotation cordic, one micro-rotation per cycle
`timescale 1ns / 1ps

module kbs_cordic #(
  parameter int CORDIC_STAGES = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic go,
  input  logic [15:0] ang,
  output logic busy,
  output logic signed [FRAC_BITS+2:0] cos_o,
  output logic signed [FRAC_BITS+2:0] sin_o
);

  localparam int CW = FRAC_BITS + 3;
  localparam int IW = $clog2(CORDIC_STAGES);
  localparam longint unsigned XINIT =
    (kbs_pkg::GAIN_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);

  logic busy_r;
  logic flip_r;
  logic [IW-1:0] i_r;
  logic signed [CW-1:0] x_r, y_r;
  logic signed [33:0] z_r;
  logic flip;
  logic [15:0] a_red;
  logic [15:0] a_off;
  logic signed [33:0] at;

  // fold left half-plane angles by half a turn
  assign a_off = ang + 16'h4000;
  assign flip = a_off[15];
  assign a_red = flip ? (ang ^ 16'h8000) : ang;
  assign at = $signed({2'b00, kbs_pkg::atan_ang(5'(i_r))});

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      i_r <= '0;
    end else if (go) begin
      busy_r <= 1'b1;
      i_r <= '0;
    end else if (busy_r) begin
      i_r <= i_r + 1'b1;
      if (i_r == IW'(CORDIC_STAGES - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // rotation datapath
  always_ff @(posedge clk) begin
    if (go) begin
      flip_r <= flip;
      x_r <= CW'(XINIT);
      y_r <= '0;
      z_r <= 34'($signed(a_red)) <<< 16;
    end else if (busy_r) begin
      if (z_r >= 0) begin
        x_r <= x_r - (y_r >>> i_r);
        y_r <= y_r + (x_r >>> i_r);
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + (y_r >>> i_r);
        y_r <= y_r - (x_r >>> i_r);
        z_r <= z_r + at;
      end
    end
  end

  assign busy = busy_r;
  assign cos_o = flip_r ? -x_r : x_r;
  assign sin_o = flip_r ? -y_r : y_r;

endmodule

@@ design/kbs_div.sv @@
// radix-2 restoring divider, signed dividend, positive divisor, truncating
`timescale 1ns / 1ps

module kbs_div (
  input  logic clk,
  input  logic rst_n,
  input  logic go,
  input  logic signed [kbs_pkg::DIV_W-1:0] num,
  input  logic [kbs_pkg::DEN_W-1:0] den,
  output logic busy,
  output logic signed [kbs_pkg::DIV_W-1:0] quot
);

  localparam int DW = kbs_pkg::DIV_W;
  localparam int SW = kbs_pkg::DEN_W;
  localparam int CNW = $clog2(DW);

  logic busy_r;
  logic [CNW-1:0] cnt_r;
  logic neg_r;
  logic [DW-1:0] q_r;
  logic [SW-1:0] rem_r;
  logic [SW-1:0] den_r;
  logic [SW:0] trial;
  logic [SW:0] diff;

  assign trial = {rem_r, q_r[DW-1]};
  assign diff = trial - {1'b0, den_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else if (go) begin
      busy_r <= 1'b1;
      cnt_r <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNW'(DW - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (go) begin
      neg_r <= num[DW-1];
      q_r <= num[DW-1] ? DW'(-num) : DW'(num);
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      if (!diff[SW]) begin
        rem_r <= diff[SW-1:0];
        q_r <= {q_r[DW-2:0], 1'b1};
      end else begin
        rem_r <= trial[SW-1:0];
        q_r <= {q_r[DW-2:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign quot = neg_r ? -$signed(q_r) : $signed(q_r);

endmodule

@@ design/kbs_ctrl.sv @@
// sequencing state machine for one euler step
`timescale 1ns / 1ps

module kbs_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  kbs_pkg::kbs_sts_t sts,
  output kbs_pkg::kbs_cmd_t cmd
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DIST  = 4'd1;
  localparam logic [3:0] ST_COS1  = 4'd2;
  localparam logic [3:0] ST_POS   = 4'd3;
  localparam logic [3:0] ST_COS2  = 4'd4;
  localparam logic [3:0] ST_DIV1  = 4'd5;
  localparam logic [3:0] ST_DIV2S = 4'd6;
  localparam logic [3:0] ST_DIV2  = 4'd7;
  localparam logic [3:0] ST_MULH  = 4'd8;
  localparam logic [3:0] ST_FIN   = 4'd9;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  // next state and commands
  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_DIST;
        end
      end
      ST_DIST: begin
        cmd.dist_calc = 1'b1;
        cmd.cordic_go = 1'b1;
        state_nxt = ST_COS1;
      end
      ST_COS1: begin
        if (!sts.cordic_busy) begin
          cmd.pos_mul = 1'b1;
          cmd.cordic_go = 1'b1;
          cmd.trig_steer = 1'b1;
          state_nxt = ST_POS;
        end
      end
      ST_POS: begin
        cmd.pos_add = 1'b1;
        state_nxt = ST_COS2;
      end
      ST_COS2: begin
        if (!sts.cordic_busy) begin
          cmd.div_go = 1'b1;
          state_nxt = ST_DIV1;
        end
      end
      ST_DIV1: begin
        if (!sts.div_busy) begin
          cmd.tan_mul = 1'b1;
          state_nxt = ST_DIV2S;
        end
      end
      ST_DIV2S: begin
        cmd.div_go = 1'b1;
        cmd.div_turn = 1'b1;
        state_nxt = ST_DIV2;
      end
      ST_DIV2: begin
        if (!sts.div_busy) begin
          cmd.mul_lo = 1'b1;
          state_nxt = ST_MULH;
        end
      end
      ST_MULH: begin
        cmd.mul_hi = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!sts.out_full) begin
          cmd.finish = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ design/kbs_datapath.sv @@
// vehicle state, configuration registers, multipliers and result register
`timescale 1ns / 1ps

module kbs_datapath #(
  parameter int CORDIC_STAGES = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  kbs_pkg::kbs_cmd_t cmd,
  output kbs_pkg::kbs_sts_t sts,
  input  logic [15:0] step_time,
  input  logic cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [14:0] cfg_wdata,
  input  logic out_ready,
  output logic out_valid,
  output logic [31:0] pos_x,
  output logic [31:0] pos_y,
  output logic [15:0] heading,
  output logic signed [23:0] speed,
  output logic signed [12:0] accel_echo,
  output logic signed [14:0] steer_echo
);

  localparam int CW = FRAC_BITS + 3;
  localparam int PW = 24 + CW;
  localparam int DW = kbs_pkg::DIV_W;
  localparam int SW = kbs_pkg::DEN_W;

  // configuration
  logic [12:0] wb_cfg_r;
  logic signed [12:0] acc_cfg_r;
  logic signed [14:0] st_cfg_r;

  // per-item operands
  logic [15:0] t_r;
  logic [12:0] wb_r;
  logic signed [12:0] acc_r;
  logic signed [14:0] st_r;
  logic signed [23:0] d_r;
  logic signed [PW-1:0] prodx_r, prody_r;
  logic signed [47:0] dt_r;
  logic [57:0] mlo_r;
  logic [27:0] mhi_r;

  // vehicle state
  logic [31:0] x_r, y_r;
  logic [15:0] yaw_r;
  logic signed [23:0] vel_r;

  // result register
  logic out_valid_r;
  logic [31:0] ox_r, oy_r;
  logic [15:0] oh_r;
  logic signed [23:0] ov_r;
  logic signed [12:0] oa_r;
  logic signed [14:0] os_r;

  logic [12:0] wb_c;
  logic signed [12:0] acc_c;
  logic signed [14:0] st_c;
  logic signed [16:0] t_s;
  logic signed [40:0] vt;
  logic signed [29:0] at;
  logic signed [24:0] vsum;
  logic signed [23:0] vsat;
  logic [15:0] cang;
  logic cordic_busy, div_busy;
  logic signed [CW-1:0] cos_w, sin_w;
  logic signed [DW-1:0] div_num, quot;
  logic [SW-1:0] div_den;
  logic [55:0] r56;
  logic [55:0] ysum;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_cfg_r <= kbs_pkg::WB_RESET;
      acc_cfg_r <= $signed(kbs_pkg::ACCEL_RESET);
      st_cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        kbs_pkg::CFG_WB:    wb_cfg_r <= cfg_wdata[12:0];
        kbs_pkg::CFG_ACCEL: acc_cfg_r <= $signed(cfg_wdata[12:0]);
        kbs_pkg::CFG_STEER: st_cfg_r <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // register clamps
  always_comb begin
    if (wb_cfg_r < kbs_pkg::WB_MIN) wb_c = kbs_pkg::WB_MIN;
    else if (wb_cfg_r > kbs_pkg::WB_MAX) wb_c = kbs_pkg::WB_MAX;
    else wb_c = wb_cfg_r;
    if (acc_cfg_r < -kbs_pkg::ACCEL_LIM) acc_c = -kbs_pkg::ACCEL_LIM;
    else if (acc_cfg_r > kbs_pkg::ACCEL_LIM) acc_c = kbs_pkg::ACCEL_LIM;
    else acc_c = acc_cfg_r;
    if (st_cfg_r < -kbs_pkg::STEER_LIM) st_c = -kbs_pkg::STEER_LIM;
    else if (st_cfg_r > kbs_pkg::STEER_LIM) st_c = kbs_pkg::STEER_LIM;
    else st_c = st_cfg_r;
  end

  // distance and speed update
  assign t_s = $signed({1'b0, t_r});
  assign vt = vel_r * t_s;
  assign at = acc_r * t_s;
  assign vsum = 25'(vel_r) + 25'(at >>> 8);
  always_comb begin
    if (vsum > 25'(kbs_pkg::SPEED_LIM)) vsat = kbs_pkg::SPEED_LIM;
    else if (vsum < -25'(kbs_pkg::SPEED_LIM)) vsat = -kbs_pkg::SPEED_LIM;
    else vsat = vsum[23:0];
  end

  // shared sin/cos unit
  assign cang = cmd.trig_steer ? 16'(st_r) : yaw_r;

  kbs_cordic #(
    .CORDIC_STAGES(CORDIC_STAGES),
    .FRAC_BITS(FRAC_BITS)
  ) u_cordic (
    .clk(clk),
    .rst_n(rst_n),
    .go(cmd.cordic_go),
    .ang(cang),
    .busy(cordic_busy),
    .cos_o(cos_w),
    .sin_o(sin_w)
  );

  // shared divider: tangent, then turn over wheel base
  assign div_num = cmd.div_turn ? DW'(dt_r) : (DW'(sin_w) <<< 16);
  assign div_den = cmd.div_turn ? SW'(wb_r) :
                   ((cos_w <= 0) ? SW'(1) : SW'(cos_w));

  kbs_div u_div (
    .clk(clk),
    .rst_n(rst_n),
    .go(cmd.div_go),
    .num(div_num),
    .den(div_den),
    .busy(div_busy),
    .quot(quot)
  );

  // turn to heading increment, low 56 bits of the product
  assign r56 = 56'(quot);
  assign ysum = mlo_r[55:0] + {mhi_r, 28'd0};

  // item datapath
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_r <= step_time;
      wb_r <= wb_c;
      acc_r <= acc_c;
      st_r <= st_c;
    end
    if (cmd.dist_calc) begin
      d_r <= vt[39:16];
    end
    if (cmd.pos_mul) begin
      prodx_r <= d_r * cos_w;
      prody_r <= d_r * sin_w;
    end
    if (cmd.tan_mul) begin
      dt_r <= d_r * $signed(quot[23:0]);
    end
    if (cmd.mul_lo) begin
      mlo_r <= r56[27:0] * kbs_pkg::INV_2PI_Q32;
    end
    if (cmd.mul_hi) begin
      mhi_r <= 28'(r56[55:28] * kbs_pkg::INV_2PI_Q32);
    end
    if (cmd.finish) begin
      ox_r <= x_r;
      oy_r <= y_r;
      oh_r <= yaw_r + ysum[55:40];
      ov_r <= vel_r;
      oa_r <= acc_r;
      os_r <= st_r;
    end
  end

  // vehicle state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= kbs_pkg::X_RESET;
      y_r <= kbs_pkg::Y_RESET;
      yaw_r <= '0;
      vel_r <= '0;
    end else begin
      if (cmd.dist_calc) vel_r <= vsat;
      if (cmd.pos_add) begin
        x_r <= x_r + 32'(prodx_r >>> FRAC_BITS);
        y_r <= y_r + 32'(prody_r >>> FRAC_BITS);
      end
      if (cmd.finish) yaw_r <= yaw_r + ysum[55:40];
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.cordic_busy = cordic_busy;
  assign sts.div_busy = div_busy;
  assign sts.out_full = out_valid_r & ~out_ready;

  assign out_valid = out_valid_r;
  assign pos_x = ox_r;
  assign pos_y = oy_r;
  assign heading = oh_r;
  assign speed = ov_r;
  assign accel_echo = oa_r;
  assign steer_echo = os_r;

endmodule

@@ design/kinematic_bicycle_step_core.sv @@
// top level of the kinematic bicycle euler step core
//
// Each item on the in_ channel is one time step (Q0.16 s). The core keeps
// position, heading and speed, does one euler step of the bicycle model
// and returns the new state as one item on the out_ channel.
// Wheel base, acceleration and steering are set over the cfg_ write
// channel, which is always ready; write them only while the core is idle.
// Each item makes two passes through the shared cordic, one stage a cycle,
// and two 46-bit passes through the shared divider, one quotient bit a
// cycle. One item is worked on at a time; the next is taken as soon as
// the current one has moved to the result register, while that result
// still waits to be taken.
// If the receiver stalls with a result still held, the finished item waits
// inside until the result register frees.
// Reset sets the position to (4.2177, 25.0248) m, heading and speed to
// zero and the registers to their defaults; no clearing pass is needed.
`timescale 1ns / 1ps

module kinematic_bicycle_step_core #(
  parameter int CORDIC_STAGES = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [15:0] in_tdata,    // [15:0] step_time
  output logic out_tvalid,
  input  logic out_tready,
  // [31:0] pos_x, [63:32] pos_y, [79:64] heading, [103:80] speed,
  // [116:104] accel_echo, [131:117] steer_echo, [135:132] zero
  output logic [135:0] out_tdata,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [14:0] cfg_data
);

  kbs_pkg::kbs_cmd_t cmd;
  kbs_pkg::kbs_sts_t sts;
  logic [31:0] pos_x, pos_y;
  logic [15:0] heading;
  logic signed [23:0] speed;
  logic signed [12:0] accel_echo;
  logic signed [14:0] steer_echo;

  assign cfg_ready = 1'b1;

  kbs_ctrl u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .sts(sts),
    .cmd(cmd)
  );

  kbs_datapath #(
    .CORDIC_STAGES(CORDIC_STAGES),
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk(clk),
    .rst_n(rst_n),
    .cmd(cmd),
    .sts(sts),
    .step_time(in_tdata),
    .cfg_we(cfg_valid & cfg_ready),
    .cfg_idx(cfg_index),
    .cfg_wdata(cfg_data),
    .out_ready(out_tready),
    .out_valid(out_tvalid),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .heading(heading),
    .speed(speed),
    .accel_echo(accel_echo),
    .steer_echo(steer_echo)
  );

  // result packing
  assign out_tdata = {4'd0, steer_echo, accel_echo, speed, heading, pos_y, pos_x};

  // checks
  `include "kinematic_bicycle_step_core_assert.svh"

  `KBS_ASSERT_NEXT(a_one_in_flight, in_tvalid && in_tready, !in_tready)
  `KBS_ASSERT_NEXT(a_no_early_result, in_tvalid && in_tready, !$rose(out_tvalid))
  `KBS_ASSERT_NOW(a_speed_sat, out_tvalid,
    (speed <= kbs_pkg::SPEED_LIM) && (speed >= -kbs_pkg::SPEED_LIM))
  `KBS_ASSERT_NOW(a_steer_clamp, out_tvalid,
    (steer_echo <= kbs_pkg::STEER_LIM) && (steer_echo >= -kbs_pkg::STEER_LIM))

endmodule
